>>> hw/rtl/stli_pkg.sv
// Shared types and constants for the sorted table linear interpolator.
package stli_pkg;

  localparam int unsigned XW = 16;
  localparam int unsigned YW = 16;
  localparam int unsigned MW = 16;
  localparam int unsigned PW = 2 * MW;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [YW-1:0] y;
  } pair_t;

  typedef struct packed {
    logic          start;
    logic [PW-1:0] dividend;
    logic [MW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [PW-1:0] quotient;
  } div_rsp_t;

endpackage

>>> hw/rtl/stli_mem.sv
// Breakpoint pair memory with one write port and one registered read port.
module stli_mem
  import stli_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  pair_t         wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output pair_t         rdata_o
);

  pair_t mem_q [DEPTH];
  pair_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/stli_div.sv
// Restoring serial divider, one quotient bit per cycle.
module stli_div
  import stli_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned CW = $clog2(PW + 1);

  logic [MW:0]   rem_q, rem_d;
  logic [PW-1:0] quo_q, quo_d;
  logic [MW-1:0] den_q, den_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [MW:0]   trial;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[MW-1:0], quo_q[PW-1]};
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.dividend;
      den_d  = req_i.divisor;
      cnt_d  = CW'(PW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[PW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[PW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

>>> hw/rtl/sorted_table_linear_interpolator_top.sv
// Top level of the sorted table linear interpolator.
// The input channel carries one command per item: the command code in
// s_tuser_i and an x and y value in s_tdata_i. A clear empties the table,
// a load appends one breakpoint pair, and a query returns the exact or
// linearly interpolated y for the given x. Every item yields one result on
// the output channel with the y value in m_tdata_o and a status in m_tuser_o.
// Clear, load and unused commands go straight to the result state. A query
// on a sorted table reads one entry at a time while it scans for the
// bracketing pair, then forms the product in the multiply state and divides
// it on the serial divider. After loads the first query sorts the table in
// place with an exchange sort that runs entirely through the one pair memory.
// Reset empties the table and marks it sorted; the memory itself is not
// cleared. A finished result sits in an output register; while the receiver
// stalls, the next item is still accepted and processed, and its result
// waits until the output register frees.
module sorted_table_linear_interpolator_top
  import stli_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [31:0] s_tdata_i,  // x_value[15:0], y_value[31:16]
  input  logic [1:0]  s_tuser_i,  // command[1:0]
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [15:0] m_tdata_o,  // y_result[15:0]
  output logic [1:0]  m_tuser_o   // status[1:0]
);

  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_ENTRIES);

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_SI   = 11'b00000000010,
    S_SIL  = 11'b00000000100,
    S_SJ   = 11'b00000001000,
    S_SJC  = 11'b00000010000,
    S_SW   = 11'b00000100000,
    S_QRD  = 11'b00001000000,
    S_QCHK = 11'b00010000000,
    S_MUL  = 11'b00100000000,
    S_DIV  = 11'b01000000000,
    S_RES  = 11'b10000000000
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          sorted_q, sorted_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d;
  logic signed [XW-1:0] qx_q, qx_d;
  pair_t         p_q, p_d, lo_q, lo_d, hi_q, hi_d;
  logic [YW-1:0] ry_q, ry_d;
  status_e       rst_q, rst_d;
  logic [PW-1:0] prod_q, prod_d;
  logic [MW-1:0] den_q, den_d;
  logic          neg_q, neg_d;
  logic          ov_q, ov_d;
  logic [YW-1:0] oy_q;
  status_e       ost_q;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  pair_t         wdata, rdata;
  div_req_t      dreq;
  div_rsp_t      drsp;

  logic          s_fire;
  logic [XW:0]   a_w, d_w;
  logic signed [YW:0] b_w;
  logic [MW-1:0] babs;
  logic signed [YW+1:0] sum_w;
  logic [CW:0]   inc_i, inc_j;

  assign s_fire = s_tvalid_i && s_tready_o;
  assign s_tready_o = (state_q == S_IDLE);

  stli_mem #(.DEPTH(MAX_ENTRIES), .AW(AW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  stli_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    sorted_d = sorted_q;
    i_d      = i_q;
    j_d      = j_q;
    qx_d     = qx_q;
    p_d      = p_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    ry_d     = ry_q;
    rst_d    = rst_q;
    prod_d   = prod_q;
    den_d    = den_q;
    neg_d    = neg_q;
    we       = 1'b0;
    waddr    = '0;
    wdata    = p_q;
    re       = 1'b0;
    raddr    = '0;
    dreq     = '0;
    inc_i    = {1'b0, i_q} + (CW+1)'(1);
    inc_j    = {1'b0, j_q} + (CW+1)'(1);
    a_w      = {hi_q.x[XW-1], hi_q.x} - {qx_q[XW-1], qx_q};
    d_w      = {hi_q.x[XW-1], hi_q.x} - {lo_q.x[XW-1], lo_q.x};
    b_w      = {lo_q.y[YW-1], lo_q.y} - {hi_q.y[YW-1], hi_q.y};
    babs     = b_w[YW] ? MW'(-b_w) : MW'(b_w);
    sum_w    = neg_q ? ({{2{hi_q.y[YW-1]}}, hi_q.y} - {2'b00, drsp.quotient[YW-1:0]})
                     : ({{2{hi_q.y[YW-1]}}, hi_q.y} + {2'b00, drsp.quotient[YW-1:0]});
    ov_d     = ov_q;

    case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          ry_d    = '0;
          rst_d   = ST_OK;
          state_d = S_RES;
          case (cmd_e'(s_tuser_i))
            CMD_CLEAR: begin
              cnt_d    = '0;
              sorted_d = 1'b1;
            end
            CMD_LOAD: begin
              if (cnt_q == MaxCnt) begin
                rst_d = ST_FULL;
              end else begin
                we       = 1'b1;
                waddr    = cnt_q[AW-1:0];
                wdata.x  = s_tdata_i[15:0];
                wdata.y  = s_tdata_i[31:16];
                cnt_d    = cnt_q + CW'(1);
                sorted_d = 1'b0;
              end
            end
            CMD_QUERY: begin
              qx_d = s_tdata_i[15:0];
              i_d  = '0;
              if (cnt_q == '0) begin
                rst_d = ST_EMPTY;
              end else if (!sorted_q) begin
                state_d = S_SI;
              end else begin
                state_d = S_QRD;
              end
            end
            default: ;
          endcase
        end
      end
      S_SI: begin
        if (inc_i >= {1'b0, cnt_q}) begin
          sorted_d = 1'b1;
          i_d      = '0;
          state_d  = S_QRD;
        end else begin
          re      = 1'b1;
          raddr   = i_q[AW-1:0];
          j_d     = inc_i[CW-1:0];
          state_d = S_SIL;
        end
      end
      S_SIL: begin
        p_d     = rdata;
        state_d = S_SJ;
      end
      S_SJ: begin
        re      = 1'b1;
        raddr   = j_q[AW-1:0];
        state_d = S_SJC;
      end
      S_SJC: begin
        if (rdata.x < p_q.x) begin
          we    = 1'b1;
          waddr = j_q[AW-1:0];
          wdata = p_q;
          p_d   = rdata;
        end
        if (inc_j < {1'b0, cnt_q}) begin
          j_d     = inc_j[CW-1:0];
          state_d = S_SJ;
        end else begin
          state_d = S_SW;
        end
      end
      S_SW: begin
        we      = 1'b1;
        waddr   = i_q[AW-1:0];
        wdata   = p_q;
        i_d     = inc_i[CW-1:0];
        state_d = S_SI;
      end
      S_QRD: begin
        re      = 1'b1;
        raddr   = i_q[AW-1:0];
        state_d = S_QCHK;
      end
      S_QCHK: begin
        if (rdata.x == qx_q) begin
          ry_d    = rdata.y;
          rst_d   = ST_OK;
          state_d = S_RES;
        end else if (rdata.x > qx_q) begin
          if (i_q == '0) begin
            ry_d    = '0;
            rst_d   = ST_RANGE;
            state_d = S_RES;
          end else begin
            lo_d    = p_q;
            hi_d    = rdata;
            state_d = S_MUL;
          end
        end else begin
          p_d = rdata;
          if (inc_i < {1'b0, cnt_q}) begin
            i_d     = inc_i[CW-1:0];
            state_d = S_QRD;
          end else begin
            ry_d    = '0;
            rst_d   = ST_RANGE;
            state_d = S_RES;
          end
        end
      end
      S_MUL: begin
        prod_d  = a_w[MW-1:0] * babs;
        den_d   = d_w[MW-1:0];
        neg_d   = b_w[YW];
        state_d = S_DIV;
        ov_d    = 1'b0;
      end
      S_DIV: begin
        if (!ov_q) begin
          dreq.start    = 1'b1;
          dreq.dividend = prod_q;
          dreq.divisor  = den_q;
          ov_d          = 1'b1;
        end else if (drsp.done) begin
          rst_d   = ST_OK;
          state_d = S_RES;
          if (sum_w > 18'sd32767) begin
            ry_d = 16'h7fff;
          end else if (sum_w < -18'sd32768) begin
            ry_d = 16'h8000;
          end else begin
            ry_d = sum_w[YW-1:0];
          end
        end
      end
      S_RES: begin
        if (!m_tvalid_o || m_tready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      sorted_q   <= 1'b1;
      m_tvalid_o <= 1'b0;
      ov_q       <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      sorted_q <= sorted_d;
      ov_q     <= ov_d;
      if (state_q == S_RES && (!m_tvalid_o || m_tready_i)) begin
        m_tvalid_o <= 1'b1;
      end else if (m_tready_i) begin
        m_tvalid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i_q    <= i_d;
    j_q    <= j_d;
    qx_q   <= qx_d;
    p_q    <= p_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    ry_q   <= ry_d;
    rst_q  <= rst_d;
    prod_q <= prod_d;
    den_q  <= den_d;
    neg_q  <= neg_d;
    if (state_q == S_RES && (!m_tvalid_o || m_tready_i)) begin
      oy_q  <= ry_q;
      ost_q <= rst_q;
    end
  end

  assign m_tdata_o = oy_q;
  assign m_tuser_o = ost_q;

endmodule

>>> hw/rtl/stli_checker.sv
// Port-level checker for the interpolator and its bind to the top level.
module stli_checker
  import stli_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_tvalid_i,
  input logic        s_tready_o,
  input logic        m_tvalid_o,
  input logic        m_tready_i,
  input logic [15:0] m_tdata_o,
  input logic [1:0]  m_tuser_o
);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o)
    else $error("Output item dropped while stalled.");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> $stable(m_tdata_o) && $stable(m_tuser_o))
    else $error("Output item changed while stalled.");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && (m_tuser_o != ST_OK) |-> m_tdata_o == '0)
    else $error("Error result carries a nonzero value.");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_o |=> !s_tready_o)
    else $error("Input taken while an item is in flight.");

endmodule

bind sorted_table_linear_interpolator_top stli_checker u_stli_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_tvalid_i),
  .s_tready_o (s_tready_o),
  .m_tvalid_o (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_o  (m_tdata_o),
  .m_tuser_o  (m_tuser_o)
);
